>>> design/tlclm_pkg.sv
// shared types and constants for the three level cache latency model
`timescale 1ns / 1ps
package tlclm_pkg;

    localparam int ADDR_W   = 32;
    localparam int LAT_W    = 16;
    localparam int CYCLE_W  = 18;
    localparam int STAMP_W  = 32;
    localparam int TOTAL_W  = 32;

    // level codes, also the reported hit level
    localparam logic [1:0] LVL_FIRST  = 2'd0;
    localparam logic [1:0] LVL_SECOND = 2'd1;
    localparam logic [1:0] LVL_THIRD  = 2'd2;
    localparam logic [1:0] LVL_MEMORY = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_FIRST_LAT  = 2'd0;
    localparam logic [1:0] CFG_SECOND_LAT = 2'd1;
    localparam logic [1:0] CFG_THIRD_LAT  = 2'd2;
    localparam logic [1:0] CFG_MEM_LAT    = 2'd3;

    typedef struct packed {
        logic       start;       // latch address, bump access counter, clear trackers
        logic       rd_en;       // read one line of the walked level
        logic [1:0] level;       // level being walked
        logic       fill_en;     // write the picked line of fill_level
        logic [1:0] fill_level;
        logic       finish;      // load the result register
        logic [1:0] result_level;
    } cmd_t;

    typedef struct packed {
        logic hit;               // compare hit on the line read last cycle
        logic pending;           // a read is in flight
        logic out_busy;          // result register still held by the receiver
    } status_t;

endpackage

>>> design/tlclm_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module tlclm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                 aclk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

>>> design/tlclm_dp.sv
// datapath: tag/stamp memories, valid bits, lru trackers, latency sums
`timescale 1ns / 1ps
module tlclm_dp #(
    parameter int N1 = 4,
    parameter int N2 = 64,
    parameter int N3 = 256,
    parameter int B1 = 256,
    parameter int B2 = 1024,
    parameter int B3 = 4096,
    parameter int CW = 9
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  tlclm_pkg::cmd_t                   cmd,
    input  logic [CW-1:0]                     rd_idx,
    output tlclm_pkg::status_t                status,
    input  logic [tlclm_pkg::ADDR_W-1:0]      in_addr,
    input  logic                              cfg_wr_en,
    input  logic [1:0]                        cfg_index,
    input  logic [tlclm_pkg::LAT_W-1:0]       cfg_wdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [1:0]                        out_level,
    output logic [tlclm_pkg::CYCLE_W-1:0]     out_cycles,
    output logic [tlclm_pkg::TOTAL_W-1:0]     out_total
);
    localparam int SW  = tlclm_pkg::STAMP_W;
    localparam int A1  = N1 > 1 ? $clog2(N1) : 1;
    localparam int A2  = N2 > 1 ? $clog2(N2) : 1;
    localparam int A3  = N3 > 1 ? $clog2(N3) : 1;
    // line sizes are powers of two, so tags are upper address bits
    localparam int L1  = $clog2(B1);
    localparam int L2  = $clog2(B2);
    localparam int L3  = $clog2(B3);
    localparam int TW1 = tlclm_pkg::ADDR_W - L1;
    localparam int TW2 = tlclm_pkg::ADDR_W - L2;
    localparam int TW3 = tlclm_pkg::ADDR_W - L3;

    logic [tlclm_pkg::ADDR_W-1:0] addr_reg;
    logic [SW-1:0]                counter_reg;
    logic [tlclm_pkg::LAT_W-1:0]  lat1_reg, lat2_reg, lat3_reg, latm_reg;
    logic                         pending_reg;
    logic [CW-1:0]                pidx_reg;
    logic [1:0]                   plvl_reg;
    logic [N1-1:0]                v1_reg;
    logic [N2-1:0]                v2_reg;
    logic [N3-1:0]                v3_reg;

    logic                         inv1_reg, inv2_reg, inv3_reg;
    logic [A1-1:0]                ii1_reg, oi1_reg;
    logic [A2-1:0]                ii2_reg, oi2_reg;
    logic [A3-1:0]                ii3_reg, oi3_reg;
    logic [SW-1:0]                oa1_reg, oa2_reg, oa3_reg;

    logic                         m_tvalid_reg;
    logic [1:0]                   lvl_out_reg;
    logic [tlclm_pkg::CYCLE_W-1:0] cyc_out_reg;
    logic [tlclm_pkg::TOTAL_W-1:0] total_reg;

    logic [TW1-1:0] t1;
    logic [TW2-1:0] t2;
    logic [TW3-1:0] t3;
    logic [TW1+SW-1:0] q1;
    logic [TW2+SW-1:0] q2;
    logic [TW3+SW-1:0] q3;
    logic [A1-1:0] pi1, pick1;
    logic [A2-1:0] pi2, pick2;
    logic [A3-1:0] pi3, pick3;
    logic h1, h2, h3, hit_now;
    logic act1, act2, act3;
    logic we1, we2, we3;
    logic [SW-1:0] age1, age2, age3;
    logic [tlclm_pkg::CYCLE_W-1:0] cycles;
    logic [tlclm_pkg::TOTAL_W:0]   sum;

    assign t1 = addr_reg[tlclm_pkg::ADDR_W-1:L1];
    assign t2 = addr_reg[tlclm_pkg::ADDR_W-1:L2];
    assign t3 = addr_reg[tlclm_pkg::ADDR_W-1:L3];
    assign pi1 = pidx_reg[A1-1:0];
    assign pi2 = pidx_reg[A2-1:0];
    assign pi3 = pidx_reg[A3-1:0];

    assign act1 = pending_reg && (plvl_reg == tlclm_pkg::LVL_FIRST);
    assign act2 = pending_reg && (plvl_reg == tlclm_pkg::LVL_SECOND);
    assign act3 = pending_reg && (plvl_reg == tlclm_pkg::LVL_THIRD);
    assign h1 = act1 && v1_reg[pi1] && (q1[TW1+SW-1:SW] == t1);
    assign h2 = act2 && v2_reg[pi2] && (q2[TW2+SW-1:SW] == t2);
    assign h3 = act3 && v3_reg[pi3] && (q3[TW3+SW-1:SW] == t3);
    assign hit_now = h1 || h2 || h3;

    assign age1 = counter_reg - q1[SW-1:0];
    assign age2 = counter_reg - q2[SW-1:0];
    assign age3 = counter_reg - q3[SW-1:0];

    assign pick1 = inv1_reg ? ii1_reg : oi1_reg;
    assign pick2 = inv2_reg ? ii2_reg : oi2_reg;
    assign pick3 = inv3_reg ? ii3_reg : oi3_reg;

    assign we1 = h1 || (cmd.fill_en && cmd.fill_level == tlclm_pkg::LVL_FIRST);
    assign we2 = h2 || (cmd.fill_en && cmd.fill_level == tlclm_pkg::LVL_SECOND);
    assign we3 = h3 || (cmd.fill_en && cmd.fill_level == tlclm_pkg::LVL_THIRD);

    tlclm_ram #(.WIDTH(TW1 + SW), .DEPTH(N1)) u_ram1 (
        .aclk(aclk), .we(we1), .waddr(h1 ? pi1 : pick1), .wdata({t1, counter_reg}),
        .re(cmd.rd_en && cmd.level == tlclm_pkg::LVL_FIRST), .raddr(rd_idx[A1-1:0]),
        .rdata(q1)
    );
    tlclm_ram #(.WIDTH(TW2 + SW), .DEPTH(N2)) u_ram2 (
        .aclk(aclk), .we(we2), .waddr(h2 ? pi2 : pick2), .wdata({t2, counter_reg}),
        .re(cmd.rd_en && cmd.level == tlclm_pkg::LVL_SECOND), .raddr(rd_idx[A2-1:0]),
        .rdata(q2)
    );
    tlclm_ram #(.WIDTH(TW3 + SW), .DEPTH(N3)) u_ram3 (
        .aclk(aclk), .we(we3), .waddr(h3 ? pi3 : pick3), .wdata({t3, counter_reg}),
        .re(cmd.rd_en && cmd.level == tlclm_pkg::LVL_THIRD), .raddr(rd_idx[A3-1:0]),
        .rdata(q3)
    );

    always_comb begin
        unique case (cmd.result_level)
            tlclm_pkg::LVL_FIRST:  cycles = tlclm_pkg::CYCLE_W'(lat1_reg);
            tlclm_pkg::LVL_SECOND: cycles = tlclm_pkg::CYCLE_W'(lat1_reg)
                                          + tlclm_pkg::CYCLE_W'(lat2_reg);
            tlclm_pkg::LVL_THIRD:  cycles = tlclm_pkg::CYCLE_W'(lat1_reg)
                                          + tlclm_pkg::CYCLE_W'(lat2_reg)
                                          + tlclm_pkg::CYCLE_W'(lat3_reg);
            default:               cycles = tlclm_pkg::CYCLE_W'(latm_reg);
        endcase
    end
    assign sum = {1'b0, total_reg} + (tlclm_pkg::TOTAL_W + 1)'(cycles);

    assign status.hit      = hit_now;
    assign status.pending  = pending_reg;
    assign status.out_busy = m_tvalid_reg && !m_tready;

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            addr_reg <= in_addr;
        end
        pidx_reg <= rd_idx;
        plvl_reg <= cmd.level;
        if (cmd.finish) begin
            lvl_out_reg <= cmd.result_level;
            cyc_out_reg <= cycles;
        end
        // trackers: first invalid line, else oldest stamp, lowest index on a tie
        if (act1) begin
            if (pi1 == '0 || age1 > oa1_reg) begin
                oa1_reg <= age1;
                oi1_reg <= pi1;
            end
            if (!v1_reg[pi1] && !inv1_reg) ii1_reg <= pi1;
        end
        if (act2) begin
            if (pi2 == '0 || age2 > oa2_reg) begin
                oa2_reg <= age2;
                oi2_reg <= pi2;
            end
            if (!v2_reg[pi2] && !inv2_reg) ii2_reg <= pi2;
        end
        if (act3) begin
            if (pi3 == '0 || age3 > oa3_reg) begin
                oa3_reg <= age3;
                oi3_reg <= pi3;
            end
            if (!v3_reg[pi3] && !inv3_reg) ii3_reg <= pi3;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counter_reg  <= '0;
            total_reg    <= '0;
            lat1_reg     <= tlclm_pkg::LAT_W'(1);
            lat2_reg     <= tlclm_pkg::LAT_W'(10);
            lat3_reg     <= tlclm_pkg::LAT_W'(100);
            latm_reg     <= tlclm_pkg::LAT_W'(1000);
            pending_reg  <= 1'b0;
            v1_reg       <= '0;
            v2_reg       <= '0;
            v3_reg       <= '0;
            inv1_reg     <= 1'b0;
            inv2_reg     <= 1'b0;
            inv3_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    tlclm_pkg::CFG_FIRST_LAT:  lat1_reg <= cfg_wdata;
                    tlclm_pkg::CFG_SECOND_LAT: lat2_reg <= cfg_wdata;
                    tlclm_pkg::CFG_THIRD_LAT:  lat3_reg <= cfg_wdata;
                    default:                   latm_reg <= cfg_wdata;
                endcase
            end
            pending_reg <= cmd.rd_en;
            if (cmd.start) begin
                counter_reg <= counter_reg + 1'b1;
                inv1_reg <= 1'b0;
                inv2_reg <= 1'b0;
                inv3_reg <= 1'b0;
            end
            if (act1 && !v1_reg[pi1]) inv1_reg <= 1'b1;
            if (act2 && !v2_reg[pi2]) inv2_reg <= 1'b1;
            if (act3 && !v3_reg[pi3]) inv3_reg <= 1'b1;
            if (cmd.fill_en) begin
                unique case (cmd.fill_level)
                    tlclm_pkg::LVL_FIRST:  v1_reg[pick1] <= 1'b1;
                    tlclm_pkg::LVL_SECOND: v2_reg[pick2] <= 1'b1;
                    default:               v3_reg[pick3] <= 1'b1;
                endcase
            end
            if (cmd.finish) begin
                m_tvalid_reg <= 1'b1;
                total_reg <= sum[tlclm_pkg::TOTAL_W] ? '1 : sum[tlclm_pkg::TOTAL_W-1:0];
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign out_level  = lvl_out_reg;
    assign out_cycles = cyc_out_reg;
    assign out_total  = total_reg;
endmodule

>>> design/tlclm_ctrl.sv
// controller: walks the levels in turn, then fills the levels above the hit
`timescale 1ns / 1ps
module tlclm_ctrl #(
    parameter int N1 = 4,
    parameter int N2 = 64,
    parameter int N3 = 256,
    parameter int CW = 9
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output tlclm_pkg::cmd_t    cmd,
    output logic [CW-1:0]      rd_idx,
    input  tlclm_pkg::status_t status
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_FILL = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [1:0]    lvl_reg, lvl_next;
    logic [1:0]    fill_reg, fill_next;
    logic [1:0]    res_reg, res_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] nlines;

    always_comb begin
        unique case (lvl_reg)
            tlclm_pkg::LVL_FIRST:  nlines = CW'(N1);
            tlclm_pkg::LVL_SECOND: nlines = CW'(N2);
            default:               nlines = CW'(N3);
        endcase
    end

    always_comb begin
        state_next = state_reg;
        lvl_next   = lvl_reg;
        fill_next  = fill_reg;
        res_next   = res_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.level        = lvl_reg;
        cmd.fill_level   = fill_reg;
        cmd.result_level = res_reg;
        s_tready   = (state_reg == S_IDLE) && aresetn;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    cmd.start  = 1'b1;
                    lvl_next   = tlclm_pkg::LVL_FIRST;
                    idx_next   = '0;
                    state_next = S_WALK;
                end
            end
            S_WALK: begin
                cmd.rd_en = (idx_reg < nlines) && !status.hit;
                if (cmd.rd_en) idx_next = idx_reg + 1'b1;
                if (status.hit) begin
                    res_next = lvl_reg;
                    if (lvl_reg == tlclm_pkg::LVL_FIRST) begin
                        state_next = S_DONE;
                    end else begin
                        fill_next  = lvl_reg - 1'b1;
                        state_next = S_FILL;
                    end
                end else if (idx_reg == nlines && !status.pending) begin
                    if (lvl_reg == tlclm_pkg::LVL_THIRD) begin
                        res_next   = tlclm_pkg::LVL_MEMORY;
                        fill_next  = tlclm_pkg::LVL_THIRD;
                        state_next = S_FILL;
                    end else begin
                        lvl_next = lvl_reg + 1'b1;
                        idx_next = '0;
                    end
                end
            end
            S_FILL: begin
                cmd.fill_en = 1'b1;
                if (fill_reg == tlclm_pkg::LVL_FIRST) begin
                    state_next = S_DONE;
                end else begin
                    fill_next = fill_reg - 1'b1;
                end
            end
            default: begin
                if (!status.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    assign rd_idx = idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            lvl_reg   <= tlclm_pkg::LVL_FIRST;
            fill_reg  <= tlclm_pkg::LVL_FIRST;
            res_reg   <= tlclm_pkg::LVL_FIRST;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            lvl_reg   <= lvl_next;
            fill_reg  <= fill_next;
            res_reg   <= res_next;
            idx_reg   <= idx_next;
        end
    end
endmodule

>>> design/three_level_cache_latency_model.sv
// Three level fully associative LRU cache latency model, top level.
// s_tdata carries one access address per transaction. For each one the block
// returns one m_tdata transaction: the level that hit (3 for main memory),
// the cycles charged for the access and the saturating running total.
// Each level is searched by walking its tag/stamp memory one line a cycle:
// a level that misses takes its N reads, the compare of the last line and one
// step on; a hit on line i ends the walk once that line is compared. Each level
// above the hit is then filled in turn, between the accept and result steps.
// The line walk over one read port per level sets the access time.
// One access is in flight at a time; s_tready is high only when idle. A
// finished result waits in the output register while the next address is
// taken; if the receiver stalls, the next result waits until it is taken.
// Configuration is a plain write port (index 0..3: first, second, third level
// and memory latency); the user writes it only while idle, the block does not enforce it.
// Reset (aresetn low, synchronous) clears all valid bits, the access counter,
// the total and restores latencies 1, 10, 100 and 1000; no clearing pass.
`timescale 1ns / 1ps
module three_level_cache_latency_model #(
    parameter int FIRST_LEVEL_LINES       = 4,
    parameter int SECOND_LEVEL_LINES      = 64,
    parameter int THIRD_LEVEL_LINES       = 256,
    parameter int FIRST_LEVEL_LINE_BYTES  = 256,
    parameter int SECOND_LEVEL_LINE_BYTES = 1024,
    parameter int THIRD_LEVEL_LINE_BYTES  = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] access_address
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,    // [1:0] hit_level, [19:2] access_cycles, [51:20] total_cycles
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);
    localparam int MAXL12 = FIRST_LEVEL_LINES > SECOND_LEVEL_LINES ?
                            FIRST_LEVEL_LINES : SECOND_LEVEL_LINES;
    localparam int MAXL   = MAXL12 > THIRD_LEVEL_LINES ? MAXL12 : THIRD_LEVEL_LINES;
    localparam int CW     = $clog2(MAXL + 1);

    tlclm_pkg::cmd_t    cmd;
    tlclm_pkg::status_t status;
    logic [CW-1:0]      rd_idx;
    logic [1:0]         out_level;
    logic [tlclm_pkg::CYCLE_W-1:0] out_cycles;
    logic [tlclm_pkg::TOTAL_W-1:0] out_total;

    tlclm_ctrl #(
        .N1(FIRST_LEVEL_LINES), .N2(SECOND_LEVEL_LINES), .N3(THIRD_LEVEL_LINES), .CW(CW)
    ) u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .cmd(cmd), .rd_idx(rd_idx), .status(status)
    );

    tlclm_dp #(
        .N1(FIRST_LEVEL_LINES), .N2(SECOND_LEVEL_LINES), .N3(THIRD_LEVEL_LINES),
        .B1(FIRST_LEVEL_LINE_BYTES), .B2(SECOND_LEVEL_LINE_BYTES),
        .B3(THIRD_LEVEL_LINE_BYTES), .CW(CW)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .rd_idx(rd_idx), .status(status),
        .in_addr(s_tdata), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .out_level(out_level), .out_cycles(out_cycles), .out_total(out_total)
    );

    assign m_tdata = {4'b0000, out_total, out_cycles, out_level};
endmodule
